/* rtl/rlt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlt_pkg: shared types and constants for the running leader timeline
// Field widths, command and status codes, and the request/response bundle
// between the top level and the timeline search unit.
// ----------------------------------------------------------------------------
package rlt_pkg;

	localparam int CAND_W   = 10;
	localparam int STAMP_W  = 32;
	localparam int LEADER_W = 10;

	// command codes carried on tuser
	localparam logic CMD_VOTE  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EARLY = 2'd1,
		ST_FULL  = 2'd2,
		ST_ORDER = 2'd3
	} status_t;

	// top level -> timeline unit
	typedef struct packed {
		logic                append;
		logic                search;
		logic [STAMP_W-1:0]  stamp;
		logic [LEADER_W-1:0] leader;
	} tl_req_t;

	// timeline unit -> top level
	typedef struct packed {
		logic                done;
		logic                early;
		logic [LEADER_W-1:0] leader;
		logic                full;
		logic                empty;
		logic [STAMP_W-1:0]  last_stamp;
	} tl_rsp_t;

endpackage

/* rtl/rlt_timeline.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlt_timeline: timeline store and binary search unit
// Holds the stamp/leader timeline in one synchronous memory. Appends write
// the next free entry; a search walks the memory one read per step and
// reports the leader of the last entry at or before the query stamp.
// ----------------------------------------------------------------------------
module rlt_timeline #(
	parameter int TIMELINE_DEPTH = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rlt_pkg::tl_req_t req,
	output rlt_pkg::tl_rsp_t rsp
);
	import rlt_pkg::*;

	localparam int TL_AW = $clog2(TIMELINE_DEPTH);
	localparam int LEN_W = $clog2(TIMELINE_DEPTH + 1);

	typedef struct packed {
		logic [LEADER_W-1:0] leader;
		logic [STAMP_W-1:0]  stamp;
	} entry_t;

	typedef enum logic [1:0] {T_IDLE, T_STEP, T_LAST} tstate_t;

	entry_t mem [TIMELINE_DEPTH];
	entry_t rd_q;

	tstate_t             state_q;
	logic [LEN_W-1:0]    len_q;
	logic                done_q;
	logic                early_q;
	logic [LEADER_W-1:0] leader_q;
	logic [STAMP_W-1:0]  first_q;
	logic [STAMP_W-1:0]  last_q;
	logic [STAMP_W-1:0]  when_q;
	logic [TL_AW-1:0]    lo_q;
	logic [TL_AW-1:0]    hi_q;
	logic [TL_AW-1:0]    mid_q;

	logic             empty;
	logic             full;
	logic             le;
	logic [TL_AW-1:0] nlo;
	logic [TL_AW-1:0] nhi;
	logic [LEN_W-1:0] span;
	logic [TL_AW-1:0] nmid;
	logic [TL_AW-1:0] mid0;
	logic [TL_AW-1:0] raddr;
	logic             early_hit;

	assign empty = (len_q == '0);
	assign full  = (len_q == LEN_W'(TIMELINE_DEPTH));
	assign mid0  = TL_AW'(len_q >> 1);
	assign early_hit = empty || (req.stamp < first_q);

	// narrow the window from the entry read last cycle
	always_comb begin
		le   = (rd_q.stamp <= when_q);
		nlo  = le ? mid_q : lo_q;
		nhi  = le ? hi_q : (mid_q - TL_AW'(1));
		span = LEN_W'(nhi) - LEN_W'(nlo) + LEN_W'(1);
		nmid = nlo + TL_AW'(span >> 1);
	end

	// select the read address for the next step
	always_comb begin
		raddr = '0;
		case (state_q)
			T_IDLE: raddr = mid0;
			T_STEP: raddr = (nlo == nhi) ? nlo : nmid;
			T_LAST: raddr = '0;
			default: raddr = '0;
		endcase
	end

	// timeline memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.append && !full) begin
			mem[TL_AW'(len_q)] <= '{leader: req.leader, stamp: req.stamp};
		end
		rd_q <= mem[raddr];
	end

	// sequence appends and search steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= T_IDLE;
			len_q    <= '0;
			done_q   <= 1'b0;
			early_q  <= 1'b0;
			leader_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (req.append && !full) begin
						len_q <= len_q + LEN_W'(1);
					end else if (req.search) begin
						if (early_hit) begin
							done_q   <= 1'b1;
							early_q  <= 1'b1;
							leader_q <= '0;
						end else if (len_q == LEN_W'(1)) begin
							state_q <= T_LAST;
						end else begin
							state_q <= T_STEP;
						end
					end
				end
				T_STEP: begin
					if (nlo == nhi) begin
						state_q <= T_LAST;
					end
				end
				T_LAST: begin
					done_q   <= 1'b1;
					early_q  <= 1'b0;
					leader_q <= rd_q.leader;
					state_q  <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// hold the search window and edge stamps
	always_ff @(posedge clk) begin
		if (state_q == T_IDLE) begin
			if (req.append && !full) begin
				last_q <= req.stamp;
				if (empty) begin
					first_q <= req.stamp;
				end
			end else if (req.search) begin
				when_q <= req.stamp;
				lo_q   <= '0;
				hi_q   <= TL_AW'(len_q - LEN_W'(1));
				mid_q  <= mid0;
			end
		end else if (state_q == T_STEP) begin
			lo_q  <= nlo;
			hi_q  <= nhi;
			mid_q <= nmid;
		end
	end

	assign rsp = '{done: done_q, early: early_q, leader: leader_q,
		full: full, empty: empty, last_stamp: last_q};

endmodule

/* rtl/running_leader_timeline.sv */
`timescale 1ns / 1ps
// Sequence: a dropped vote goes from dispatch straight to emit; a counted vote passes
// the read and update states (and the candidate reduction state when CANDIDATES < 1024)
// before emit; a query waits in the search state for the timeline unit, then emits.
// Flow: one item in work at a time; the next is taken the cycle after the result is
// registered in the output register.
// Reset: a clearing pass writes every count memory entry to zero before the first item.
// ----------------------------------------------------------------------------
// running_leader_timeline: vote tally with a searchable leader timeline
// Accepted votes update a per-candidate count memory and append the leader to a
// timeline; queries binary-search the timeline for the leader at a time.
// ----------------------------------------------------------------------------
module running_leader_timeline #(
	parameter int CANDIDATES     = 1024,
	parameter int TIMELINE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // candidate[9:0], stamp[41:10], zero pad
	input  logic [0:0]  s_tuser,   // command[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // leader[9:0], status[11:10], zero pad
);
	import rlt_pkg::*;

	localparam int CA_W  = (CANDIDATES > 1) ? $clog2(CANDIDATES) : 1;
	localparam int CNT_W = $clog2(TIMELINE_DEPTH + 1);
	localparam bit NEED_MOD = (CANDIDATES < (1 << CAND_W));
	// reciprocal for the candidate reduction: quotient = (candidate * QM) >> QS
	localparam int QS   = CAND_W + CA_W;
	localparam int QM_W = CAND_W + 2;
	localparam int QP_W = CAND_W + QM_W;
	localparam int BK_W = CAND_W + CA_W + 1;
	localparam longint unsigned QM =
		((64'd1 << QS) + 64'(CANDIDATES) - 64'd1) / 64'(CANDIDATES);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_DISPATCH, S_MOD, S_READ, S_UPD, S_SEARCH, S_EMIT
	} state_t;

	logic [CNT_W-1:0] cnt_mem [CANDIDATES];
	logic [CNT_W-1:0] cnt_rd_q;

	state_t              state_q;
	logic [CA_W-1:0]     clr_q;
	logic                cmd_q;
	logic [STAMP_W-1:0]  stamp_q;
	logic [CAND_W-1:0]   r_q;
	logic [CAND_W-1:0]   quo_q;
	logic [LEADER_W-1:0] cur_leader_q;
	logic [CNT_W-1:0]    lv_q;
	logic [LEADER_W-1:0] pend_leader_q;
	status_t             pend_status_q;
	logic                m_tvalid_q;
	logic [LEADER_W-1:0] out_leader_q;
	status_t             out_status_q;

	logic                out_free;
	logic [CNT_W-1:0]    newc;
	logic                take;
	logic [LEADER_W-1:0] next_leader;
	logic [QP_W-1:0]     quo_prod;
	logic [CAND_W-1:0]   quo_next;
	logic [BK_W-1:0]     quo_back;
	logic                cnt_we;
	logic [CA_W-1:0]     cnt_waddr;
	logic [CNT_W-1:0]    cnt_wdata;
	tl_req_t             tl_req;
	tl_rsp_t             tl_rsp;

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !m_tvalid_q || m_tready;

	// count update and leader takeover
	assign newc        = cnt_rd_q + CNT_W'(1);
	assign take        = (newc >= lv_q);
	assign next_leader = take ? LEADER_W'(r_q) : cur_leader_q;

	// candidate reduction: quotient by reciprocal, then one multiple back
	assign quo_prod = QP_W'(r_q) * QP_W'(QM);
	assign quo_next = CAND_W'(quo_prod >> QS);
	assign quo_back = BK_W'(quo_q) * BK_W'(CANDIDATES);

	// count memory write: clearing pass or vote update
	always_comb begin
		cnt_we    = (state_q == S_CLEAR) || (state_q == S_UPD);
		cnt_waddr = (state_q == S_CLEAR) ? clr_q : CA_W'(r_q);
		cnt_wdata = (state_q == S_CLEAR) ? '0 : newc;
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		cnt_rd_q <= cnt_mem[CA_W'(r_q)];
	end

	// drive the timeline unit
	always_comb begin
		tl_req.append = (state_q == S_UPD);
		tl_req.search = (state_q == S_DISPATCH) && (cmd_q == CMD_QUERY);
		tl_req.stamp  = stamp_q;
		tl_req.leader = next_leader;
	end

	rlt_timeline #(
		.TIMELINE_DEPTH(TIMELINE_DEPTH)
	) u_timeline (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tl_req),
		.rsp    (tl_rsp)
	);

	// main sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			cmd_q         <= CMD_VOTE;
			stamp_q       <= '0;
			r_q           <= '0;
			quo_q         <= '0;
			cur_leader_q  <= '0;
			lv_q          <= '0;
			pend_leader_q <= '0;
			pend_status_q <= ST_OK;
			m_tvalid_q    <= 1'b0;
			out_leader_q  <= '0;
			out_status_q  <= ST_OK;
		end else begin
			// load or drop the output item when the register is free
			if (out_free) begin
				m_tvalid_q <= (state_q == S_EMIT);
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CA_W'(1);
					if (clr_q == CA_W'(CANDIDATES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser[0];
						r_q     <= s_tdata[CAND_W-1:0];
						stamp_q <= s_tdata[CAND_W +: STAMP_W];
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (cmd_q == CMD_QUERY) begin
						state_q <= S_SEARCH;
					end else if (tl_rsp.full) begin
						pend_leader_q <= cur_leader_q;
						pend_status_q <= ST_FULL;
						state_q       <= S_EMIT;
					end else if (!tl_rsp.empty && (stamp_q <= tl_rsp.last_stamp)) begin
						pend_leader_q <= cur_leader_q;
						pend_status_q <= ST_ORDER;
						state_q       <= S_EMIT;
					end else if (NEED_MOD) begin
						quo_q   <= quo_next;
						state_q <= S_MOD;
					end else begin
						state_q <= S_READ;
					end
				end
				S_MOD: begin
					// subtract the quotient multiple to finish the reduction
					r_q     <= r_q - CAND_W'(quo_back);
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (take) begin
						cur_leader_q <= LEADER_W'(r_q);
						lv_q         <= newc;
					end
					pend_leader_q <= next_leader;
					pend_status_q <= ST_OK;
					state_q       <= S_EMIT;
				end
				S_SEARCH: begin
					if (tl_rsp.done) begin
						pend_leader_q <= tl_rsp.early ? '0 : tl_rsp.leader;
						pend_status_q <= tl_rsp.early ? ST_EARLY : ST_OK;
						state_q       <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_leader_q <= pend_leader_q;
						out_status_q <= pend_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, out_status_q, out_leader_q};

`ifndef SYNTH
	// the leader's count never falls
	a_lv_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		lv_q >= $past(lv_q))
		else $error("leader vote count decreased");

	// a new result comes only from the emit state
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == S_EMIT))
		else $error("result raised outside emit");

	// search completion only while the sequencer waits for it
	a_search_done: assert property (@(posedge clk) disable iff (!arst_n)
		tl_rsp.done |-> (state_q == S_SEARCH))
		else $error("timeline search finished while not awaited");
`endif

endmodule
